@@ hdl/fhcf_pkg.sv @@
// Package of the fall hint confirmation filter: payload structs, configuration
// and state structs, register indexes, reason codes and reset values.
// No dependencies.
package fhcf_pkg;

	// Bit of the radar status byte that marks the radar as offline.
	localparam int unsigned OFFLINE_BIT = 0;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_THRESHOLD       = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_LOW_ACTIVITY_THRESHOLD = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_CONFIRM_COUNT   = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_FEATURE_CONFIRM_COUNT  = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_ACTIVITY_HOLD_TICKS    = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_ALERT_HOLD_TICKS       = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_OBSERVE_DURATION_MS    = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_FALL_HINT_MASK         = 3'd7;

	// Reset values of the configuration registers.
	localparam logic [7:0]  RST_ACTIVE_THRESHOLD       = 8'd20;
	localparam logic [7:0]  RST_LOW_ACTIVITY_THRESHOLD = 8'd10;
	localparam logic [3:0]  RST_ACTIVE_CONFIRM_COUNT   = 4'd2;
	localparam logic [3:0]  RST_FEATURE_CONFIRM_COUNT  = 4'd2;
	localparam logic [7:0]  RST_ACTIVITY_HOLD_TICKS    = 8'd60;
	localparam logic [7:0]  RST_ALERT_HOLD_TICKS       = 8'd20;
	localparam logic [31:0] RST_OBSERVE_DURATION_MS    = 32'd10000;
	localparam logic [7:0]  RST_FALL_HINT_MASK         = 8'd7;

	// Reason codes of a result.
	localparam logic [2:0] REASON_NONE       = 3'd0;
	localparam logic [2:0] REASON_OFFLINE    = 3'd1;
	localparam logic [2:0] REASON_CONFIRMED  = 3'd2;
	localparam logic [2:0] REASON_CONFIRMING = 3'd3;
	localparam logic [2:0] REASON_NO_ACTIVE  = 3'd4;
	localparam logic [2:0] REASON_LOW_ACT    = 3'd5;

	typedef struct packed {
		logic [7:0]  motion;
		logic [7:0]  status_byte;
		logic [7:0]  fall_hint_bits;
		logic [31:0] static_ms;
	} pkt_t;

	typedef struct packed {
		logic       suspected_fall;
		logic       low_activity_observe;
		logic [2:0] reason_code;
	} res_t;

	typedef struct packed {
		logic [7:0]  active_threshold;
		logic [7:0]  low_activity_threshold;
		logic [3:0]  active_confirm_count;
		logic [3:0]  feature_confirm_count;
		logic [7:0]  activity_hold_ticks;
		logic [7:0]  alert_hold_ticks;
		logic [31:0] observe_duration_ms;
		logic [7:0]  fall_hint_mask;
	} cfg_t;

	typedef struct packed {
		logic [3:0] active_run;
		logic [3:0] hint_run;
		logic [7:0] activity_left;
		logic [7:0] alert_left;
		logic       activity_seen;
	} state_t;

endpackage

@@ hdl/fhcf_cfg_regs.sv @@
// Configuration register bank of the fall hint confirmation filter.
// Depends on fhcf_pkg.
module fhcf_cfg_regs
	import fhcf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   wr_en,
	input  logic [CFG_INDEX_W-1:0] wr_index,
	input  logic [CFG_DATA_W-1:0]  wr_data,
	output cfg_t                   cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_threshold       <= RST_ACTIVE_THRESHOLD;
			cfg_q.low_activity_threshold <= RST_LOW_ACTIVITY_THRESHOLD;
			cfg_q.active_confirm_count   <= RST_ACTIVE_CONFIRM_COUNT;
			cfg_q.feature_confirm_count  <= RST_FEATURE_CONFIRM_COUNT;
			cfg_q.activity_hold_ticks    <= RST_ACTIVITY_HOLD_TICKS;
			cfg_q.alert_hold_ticks       <= RST_ALERT_HOLD_TICKS;
			cfg_q.observe_duration_ms    <= RST_OBSERVE_DURATION_MS;
			cfg_q.fall_hint_mask         <= RST_FALL_HINT_MASK;
		end else if (wr_en) begin
			case (wr_index)
				REG_ACTIVE_THRESHOLD:       cfg_q.active_threshold       <= wr_data[7:0];
				REG_LOW_ACTIVITY_THRESHOLD: cfg_q.low_activity_threshold <= wr_data[7:0];
				REG_ACTIVE_CONFIRM_COUNT:   cfg_q.active_confirm_count   <= wr_data[3:0];
				REG_FEATURE_CONFIRM_COUNT:  cfg_q.feature_confirm_count  <= wr_data[3:0];
				REG_ACTIVITY_HOLD_TICKS:    cfg_q.activity_hold_ticks    <= wr_data[7:0];
				REG_ALERT_HOLD_TICKS:       cfg_q.alert_hold_ticks       <= wr_data[7:0];
				REG_OBSERVE_DURATION_MS:    cfg_q.observe_duration_ms    <= wr_data[31:0];
				REG_FALL_HINT_MASK:         cfg_q.fall_hint_mask         <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ hdl/fhcf_step.sv @@
// Per-packet update of the fall hint confirmation filter: next state and
// result from the current state, one packet and the configuration.
// Depends on fhcf_pkg.
module fhcf_step
	import fhcf_pkg::*;
(
	input  pkt_t   pkt,
	input  cfg_t   cfg,
	input  state_t st,
	output state_t st_next,
	output res_t   res
);

	logic       offline;
	logic       active;
	logic       hint;
	logic [3:0] active_run_inc;
	logic [3:0] hint_run_inc;
	logic [3:0] active_run_n;
	logic [3:0] hint_run_n;
	logic [7:0] activity_left_n;
	logic       activity_seen_n;
	logic [7:0] alert_load;
	logic       low_observe;

	always_comb begin
		offline = pkt.status_byte[OFFLINE_BIT];
		active  = pkt.motion > cfg.active_threshold;
		hint    = |(pkt.fall_hint_bits & cfg.fall_hint_mask);

		// Run counters saturate at their confirm count.
		active_run_inc = (st.active_run < cfg.active_confirm_count) ?
			st.active_run + 4'd1 : st.active_run;
		hint_run_inc = (st.hint_run < cfg.feature_confirm_count) ?
			st.hint_run + 4'd1 : st.hint_run;

		if (active) begin
			active_run_n    = active_run_inc;
			activity_seen_n = st.activity_seen | (active_run_inc >= cfg.active_confirm_count);
			activity_left_n = cfg.activity_hold_ticks;
		end else begin
			active_run_n    = 4'd0;
			activity_seen_n = st.activity_seen;
			activity_left_n = (st.activity_left != 8'd0) ?
				st.activity_left - 8'd1 : st.activity_left;
		end

		hint_run_n = (hint && activity_left_n != 8'd0) ? hint_run_inc : 4'd0;

		alert_load = (hint_run_n >= cfg.feature_confirm_count) ?
			cfg.alert_hold_ticks : st.alert_left;

		low_observe = activity_seen_n &&
			(pkt.motion <= cfg.low_activity_threshold) &&
			(pkt.static_ms >= cfg.observe_duration_ms);

		st_next.active_run    = active_run_n;
		st_next.hint_run      = hint_run_n;
		st_next.activity_left = activity_left_n;
		st_next.activity_seen = activity_seen_n;
		st_next.alert_left    = alert_load;
		res = '{suspected_fall: 1'b0, low_activity_observe: 1'b0, reason_code: REASON_NONE};

		if (offline) begin
			st_next = '0;
			res.reason_code = REASON_OFFLINE;
		end else if (alert_load != 8'd0) begin
			st_next.alert_left = alert_load - 8'd1;
			res.suspected_fall = 1'b1;
			res.reason_code    = REASON_CONFIRMED;
		end else if (hint) begin
			res.reason_code = (activity_left_n != 8'd0) ? REASON_CONFIRMING : REASON_NO_ACTIVE;
		end else if (low_observe) begin
			res.low_activity_observe = 1'b1;
			res.reason_code          = REASON_LOW_ACT;
		end
	end

endmodule

@@ hdl/fall_hint_confirmation_filter_core.sv @@
// Top level of the fall hint confirmation filter: input register, step logic,
// state and result register. Depends on fhcf_pkg, fhcf_cfg_regs, fhcf_step.

// The filter takes one radar packet per clock while res is not stalled and
// returns exactly one result per packet, in order. A packet transfer on the pkt
// channel lands in an input register; the step logic works out the result and
// the new filter state from that packet, and both are registered together when
// the packet moves on, after which the result is offered on the res channel.
// Without back-pressure the sustained rate is one packet per cycle, set by the
// loop from the state registers through the step logic back to the state
// registers. The input register only moves on while the result register is
// empty or its result is being transferred, so back-pressure on res holds at
// most one result and one packet inside the block. Configuration writes on the
// cfg channel are always taken, one per cycle; they should be made while no
// packet is in flight. A radar-offline packet clears the filter state but
// leaves the configuration registers as they are.
module fall_hint_confirmation_filter_core
	import fhcf_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// Packet channel.
	input  logic                   pkt_valid,
	output logic                   pkt_ready,
	input  pkt_t                   pkt,
	// Result channel.
	output logic                   res_valid,
	input  logic                   res_ready,
	output res_t                   res,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	cfg_t   cfg;
	pkt_t   pkt_s1;
	logic   pkt_valid_s1;
	state_t st_q;
	state_t st_next;
	res_t   res_comb;
	res_t   res_s2;
	logic   res_valid_s2;
	logic   advance;

	// The register bank accepts a write in every cycle.
	assign cfg_ready = 1'b1;

	fhcf_cfg_regs u_cfg_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	// A packet in the input register moves on when the result register is
	// free or its result is being transferred in this cycle.
	assign advance   = pkt_valid_s1 && (!res_valid_s2 || res_ready);
	assign pkt_ready = !pkt_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pkt_valid_s1 <= 1'b0;
		end else if (pkt_ready) begin
			pkt_valid_s1 <= pkt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_valid && pkt_ready) begin
			pkt_s1 <= pkt;
		end
	end

	fhcf_step u_step (
		.pkt     (pkt_s1),
		.cfg     (cfg),
		.st      (st_q),
		.st_next (st_next),
		.res     (res_comb)
	);

	// The filter state only changes when a packet's result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (advance) begin
			st_q <= st_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_s2 <= 1'b0;
		end else if (advance) begin
			res_valid_s2 <= 1'b1;
		end else if (res_ready) begin
			res_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign res_valid = res_valid_s2;
	assign res       = res_s2;

endmodule

@@ hdl/fhcf_checker.sv @@
// Port-level checker of the fall hint confirmation filter, bound to the top
// level. Depends on fhcf_pkg and fall_hint_confirmation_filter_core.
module fhcf_checker
	import fhcf_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic res_valid,
	input logic res_ready,
	input res_t res
);

	// A stalled result stays offered and unchanged.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res))
		else $error("result changed or dropped while stalled");

	// Only reasons zero to five are ever produced.
	a_reason_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.reason_code <= REASON_LOW_ACT)
		else $error("reason code out of range");

	// A suspected fall is only reported with the confirmed reason.
	a_fall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.suspected_fall |-> res.reason_code == REASON_CONFIRMED)
		else $error("suspected fall without confirmed reason");

	// The low activity flag goes with its reason, and never with a fall.
	a_low_reason: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.low_activity_observe |->
			res.reason_code == REASON_LOW_ACT && !res.suspected_fall)
		else $error("low activity flag with wrong reason");

endmodule

bind fall_hint_confirmation_filter_core fhcf_checker u_fhcf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.res_valid (res_valid),
	.res_ready (res_ready),
	.res       (res)
);

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for fall_hint_confirmation_filter_core: a directed table,
// then randomised packet bursts under changing settings, checked against a predictor.
// Depends on fhcf_pkg and the filter RTL only.

module tb;
	import fhcf_pkg::*;

	// A stretch of this many cycles without any transfer on any channel means the
	// block has hung.
	localparam int WATCHDOG_LIMIT = 1000;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 100;
	localparam int MAX_REPORTS    = 10;
	// Directed rows either carry a result typed in by hand or leave it to the predictor.
	localparam bit TYPED   = 1'b1;
	localparam bit PREDICT = 1'b0;

	// Kinds of random burst. Runs of one kind build up the confirm counters, so
	// that most of the random traffic gets past the first states of the filter.
	typedef enum int {
		BURST_ACTIVE,
		BURST_HINT_ACTIVE,
		BURST_HINT_QUIET,
		BURST_LOW,
		BURST_NOISE,
		BURST_OFFLINE
	} burst_t;

	// One row of the directed table: either a register write or a packet.
	typedef struct {
		bit                     is_write;
		logic [CFG_INDEX_W-1:0] idx;
		logic [CFG_DATA_W-1:0]  val;
		pkt_t                   p;
		bit                     typed;
		logic [2:0]             reason;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   pkt_valid;
	logic                   pkt_ready;
	pkt_t                   pkt;
	logic                   res_valid;
	logic                   res_ready = 1'b0;
	res_t                   res;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// The predictor's own copy of the settings and of the filter state.
	cfg_t   filter_cfg;
	state_t filter_st;

	res_t      pending_results[$];
	plan_row_t directed_plan[$];

	int mismatches      = 0;
	int results_checked = 0;
	int res_transfers   = 0;
	int packets_sent    = 0;
	int reg_writes      = 0;
	int idle_cycles     = 0;
	int reason_seen[8]  = '{default: 0};
	bit tx_idle_on      = 1'b1;
	bit rx_idle_on      = 1'b1;

	fall_hint_confirmation_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Advances the predicted filter state by one packet and returns the result that
	// the packet should produce.
	function automatic res_t filter_step(input pkt_t p);
		res_t r;
		logic hint;
		r = '0;
		if (p.status_byte[OFFLINE_BIT]) begin
			// Offline wipes the state but leaves the settings alone.
			filter_st = '0;
			r.reason_code = REASON_OFFLINE;
		end else begin
			if (p.motion > filter_cfg.active_threshold) begin
				if (filter_st.active_run < filter_cfg.active_confirm_count)
					filter_st.active_run = filter_st.active_run + 4'd1;
				if (filter_st.active_run >= filter_cfg.active_confirm_count)
					filter_st.activity_seen = 1'b1;
				filter_st.activity_left = filter_cfg.activity_hold_ticks;
			end else begin
				filter_st.active_run = '0;
				if (filter_st.activity_left != 0)
					filter_st.activity_left = filter_st.activity_left - 8'd1;
			end

			hint = (p.fall_hint_bits & filter_cfg.fall_hint_mask) != 0;
			if (hint && filter_st.activity_left != 0) begin
				if (filter_st.hint_run < filter_cfg.feature_confirm_count)
					filter_st.hint_run = filter_st.hint_run + 4'd1;
			end else begin
				filter_st.hint_run = '0;
			end
			if (filter_st.hint_run >= filter_cfg.feature_confirm_count)
				filter_st.alert_left = filter_cfg.alert_hold_ticks;

			// A running alert hold outranks a fresh hint, which outranks low activity.
			if (filter_st.alert_left != 0) begin
				filter_st.alert_left = filter_st.alert_left - 8'd1;
				r.suspected_fall = 1'b1;
				r.reason_code = REASON_CONFIRMED;
			end else if (hint) begin
				r.reason_code = (filter_st.activity_left != 0) ? REASON_CONFIRMING
				                                              : REASON_NO_ACTIVE;
			end else if (filter_st.activity_seen &&
			             p.motion <= filter_cfg.low_activity_threshold &&
			             p.static_ms >= filter_cfg.observe_duration_ms) begin
				r.low_activity_observe = 1'b1;
				r.reason_code = REASON_LOW_ACT;
			end
		end
		return r;
	endfunction

	function automatic void add_packet(input logic [7:0] motion, input logic [7:0] status,
	                                   input logic [7:0] hints, input logic [31:0] still_ms,
	                                   input bit typed, input logic [2:0] reason);
		plan_row_t row;
		row.is_write = 1'b0;
		row.idx      = REG_ACTIVE_THRESHOLD;
		row.val      = '0;
		row.p        = {motion, status, hints, still_ms};
		row.typed    = typed;
		row.reason   = reason;
		directed_plan.push_back(row);
	endfunction

	function automatic void add_setting(input logic [CFG_INDEX_W-1:0] idx,
	                                    input logic [CFG_DATA_W-1:0] val);
		plan_row_t row;
		row.is_write = 1'b1;
		row.idx      = idx;
		row.val      = val;
		row.p        = '0;
		row.typed    = PREDICT;
		row.reason   = REASON_NONE;
		directed_plan.push_back(row);
	endfunction

	// Writes one register once the block has gone quiet: the packet channel is
	// lowered and every outstanding result must have been transferred first.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
	                         input logic [CFG_DATA_W-1:0] val);
		if (pkt_valid) begin
			@(negedge clk);
			pkt_valid = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_ACTIVE_THRESHOLD:       filter_cfg.active_threshold       = val[7:0];
			REG_LOW_ACTIVITY_THRESHOLD: filter_cfg.low_activity_threshold = val[7:0];
			REG_ACTIVE_CONFIRM_COUNT:   filter_cfg.active_confirm_count   = val[3:0];
			REG_FEATURE_CONFIRM_COUNT:  filter_cfg.feature_confirm_count  = val[3:0];
			REG_ACTIVITY_HOLD_TICKS:    filter_cfg.activity_hold_ticks    = val[7:0];
			REG_ALERT_HOLD_TICKS:       filter_cfg.alert_hold_ticks       = val[7:0];
			REG_OBSERVE_DURATION_MS:    filter_cfg.observe_duration_ms    = val;
			REG_FALL_HINT_MASK:         filter_cfg.fall_hint_mask         = val[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Offers one packet after a random gap and records its expected result at the
	// edge where the transfer happens. With no gap, valid simply stays high and the
	// payload is replaced, so valid is never dropped and raised in the same step.
	task automatic send_packet(input pkt_t p, input bit typed, input logic [2:0] reason);
		int   gap;
		res_t outcome;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			@(negedge clk);
			pkt_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		pkt       = p;
		pkt_valid = 1'b1;
		do @(posedge clk); while (!pkt_ready);
		outcome = filter_step(p);
		if (typed)
			outcome = {1'b0, 1'b0, reason};
		pending_results.push_back(outcome);
		packets_sent++;
	endtask

	// The result side draws a fresh stall for every result it takes. The count of
	// result transfers tells this block when the last one went through.
	always @(negedge clk) begin : res_ready_drive
		int rx_seen;
		int rx_wait;
		if (res_transfers != rx_seen) begin
			rx_seen = res_transfers;
			rx_wait = rx_idle_on ? $urandom_range(0, 7) : 0;
		end
		if (rx_wait > 0) begin
			res_ready = 1'b0;
			rx_wait--;
		end else begin
			res_ready = 1'b1;
		end
	end

	// Every result transfer is compared, field by field, with the oldest outstanding
	// expectation. The same block keeps the watchdog on all three channels.
	always @(posedge clk) begin : res_check
		res_t want;
		bit   moved;
		moved = (pkt_valid && pkt_ready) || (cfg_valid && cfg_ready) ||
		        (res_valid && res_ready);
		if (arst_n && res_valid && res_ready) begin
			res_transfers++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display({"%0t: result with no packet outstanding: ",
					          "fall=%0b low=%0b reason=%0d"},
					         $realtime, res.suspected_fall, res.low_activity_observe,
					         res.reason_code);
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				reason_seen[res.reason_code]++;
				if (res.suspected_fall !== want.suspected_fall ||
				    res.low_activity_observe !== want.low_activity_observe ||
				    res.reason_code !== want.reason_code) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display({"%0t: result %0d: expected fall=%0b low=%0b reason=%0d, ",
						          "got fall=%0b low=%0b reason=%0d"},
						         $realtime, results_checked, want.suspected_fall,
						         want.low_activity_observe, want.reason_code,
						         res.suspected_fall, res.low_activity_observe,
						         res.reason_code);
				end
			end
		end
		idle_cycles = moved ? 0 : idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
			         $realtime, idle_cycles, pending_results.size());
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		plan_row_t row;
		pkt_t      p;
		burst_t    mode;
		int        run_left;
		int        pick;
		int        thr;
		int        low_thr;
		logic [7:0]  mask;
		logic [31:0] obs;

		arst_n    = 1'b0;
		pkt_valid = 1'b0;
		pkt       = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ACTIVE_THRESHOLD;
		cfg_data  = '0;

		filter_cfg.active_threshold       = RST_ACTIVE_THRESHOLD;
		filter_cfg.low_activity_threshold = RST_LOW_ACTIVITY_THRESHOLD;
		filter_cfg.active_confirm_count   = RST_ACTIVE_CONFIRM_COUNT;
		filter_cfg.feature_confirm_count  = RST_FEATURE_CONFIRM_COUNT;
		filter_cfg.activity_hold_ticks    = RST_ACTIVITY_HOLD_TICKS;
		filter_cfg.alert_hold_ticks       = RST_ALERT_HOLD_TICKS;
		filter_cfg.observe_duration_ms    = RST_OBSERVE_DURATION_MS;
		filter_cfg.fall_hint_mask         = RST_FALL_HINT_MASK;
		filter_st = '0;

		// Directed table, first under the reset settings.
		// A quiet packet straight after reset, then a hint with no activity behind it.
		add_packet(8'd0, 8'h00, 8'h00, 32'd0, TYPED, REASON_NONE);
		add_packet(8'd0, 8'h00, 8'h01, 32'd0, TYPED, REASON_NO_ACTIVE);
		// Full motion with every status bit but the offline one set.
		add_packet(8'd255, 8'hFE, 8'h00, 32'hFFFF_FFFF, PREDICT, REASON_NONE);
		// Two hints during activity confirm the alert; the quiet packet after it
		// shows the running hold taking priority.
		add_packet(8'd255, 8'h00, 8'h07, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd255, 8'h00, 8'h04, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, PREDICT, REASON_NONE);
		// Offline with everything else at its maximum clears the filter.
		add_packet(8'd255, 8'h01, 8'hFF, 32'hFFFF_FFFF, TYPED, REASON_OFFLINE);
		// Feature bits outside the mask are not a hint; activity just above threshold.
		add_packet(8'd21, 8'h00, 8'hF8, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd21, 8'h00, 8'h00, 32'd0, PREDICT, REASON_NONE);
		// Low activity exactly on both limits, one millisecond short, one motion step high.
		add_packet(8'd10, 8'h00, 8'h00, 32'd10000, PREDICT, REASON_NONE);
		add_packet(8'd10, 8'h00, 8'h00, 32'd9999, PREDICT, REASON_NONE);
		add_packet(8'd11, 8'h00, 8'h00, 32'hFFFF_FFFF, PREDICT, REASON_NONE);
		// A hint run broken by a packet without a hint starts again from one.
		add_packet(8'd30, 8'h00, 8'h01, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd30, 8'h00, 8'h00, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd30, 8'h00, 8'h02, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd0, 8'hFF, 8'h00, 32'd0, TYPED, REASON_OFFLINE);

		// Upper extremes: nothing can count as active, every feature bit is a hint.
		add_setting(REG_ACTIVE_THRESHOLD, 32'd255);
		add_setting(REG_LOW_ACTIVITY_THRESHOLD, 32'd255);
		add_setting(REG_ACTIVE_CONFIRM_COUNT, 32'd15);
		add_setting(REG_FEATURE_CONFIRM_COUNT, 32'd15);
		add_setting(REG_ACTIVITY_HOLD_TICKS, 32'd255);
		add_setting(REG_ALERT_HOLD_TICKS, 32'd0);
		add_setting(REG_OBSERVE_DURATION_MS, 32'd0);
		add_setting(REG_FALL_HINT_MASK, 32'hFF);
		add_packet(8'd255, 8'h00, 8'h80, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd0, 8'h00, 8'h00, 32'd0, PREDICT, REASON_NONE);

		// Lower extremes with single-packet confirmation and a zero alert hold, so a
		// confirmed hint still reports no fall.
		add_setting(REG_ACTIVE_THRESHOLD, 32'd0);
		add_setting(REG_LOW_ACTIVITY_THRESHOLD, 32'd0);
		add_setting(REG_ACTIVE_CONFIRM_COUNT, 32'd1);
		add_setting(REG_FEATURE_CONFIRM_COUNT, 32'd1);
		add_setting(REG_OBSERVE_DURATION_MS, 32'hFFFF_FFFF);
		add_packet(8'd1, 8'h00, 8'h01, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd0, 8'h00, 8'h00, 32'hFFFF_FFFF, PREDICT, REASON_NONE);

		// Confirm counts of zero are met by every packet; an empty mask sees no hint.
		add_setting(REG_ACTIVE_CONFIRM_COUNT, 32'd0);
		add_setting(REG_FEATURE_CONFIRM_COUNT, 32'd0);
		add_setting(REG_ALERT_HOLD_TICKS, 32'd255);
		add_setting(REG_ACTIVITY_HOLD_TICKS, 32'd0);
		add_setting(REG_FALL_HINT_MASK, 32'h00);
		add_packet(8'd0, 8'h00, 8'hFF, 32'd0, PREDICT, REASON_NONE);
		add_packet(8'd1, 8'h01, 8'h00, 32'd0, TYPED, REASON_OFFLINE);
		add_packet(8'd1, 8'h00, 8'h00, 32'd0, PREDICT, REASON_NONE);

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < directed_plan.size(); i++) begin
			row = directed_plan[i];
			if (row.is_write)
				write_reg(row.idx, row.val);
			else
				send_packet(row.p, row.typed, row.reason);
		end

		// Random part: each phase picks new settings, mostly in the range where the
		// confirmation logic can be reached, now and then at an extreme.
		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			write_reg(REG_ACTIVE_THRESHOLD, ($urandom_range(0, 7) == 0) ?
			          ($urandom_range(0, 1) ? 32'd255 : 32'd0) : $urandom_range(10, 200));
			write_reg(REG_LOW_ACTIVITY_THRESHOLD, $urandom_range(0, 255));
			write_reg(REG_ACTIVE_CONFIRM_COUNT, ($urandom_range(0, 7) == 0) ?
			          32'd15 : $urandom_range(1, 4));
			write_reg(REG_FEATURE_CONFIRM_COUNT, ($urandom_range(0, 7) == 0) ?
			          32'd15 : $urandom_range(1, 4));
			write_reg(REG_ACTIVITY_HOLD_TICKS, ($urandom_range(0, 7) == 0) ?
			          ($urandom_range(0, 1) ? 32'd255 : 32'd0) : $urandom_range(2, 40));
			write_reg(REG_ALERT_HOLD_TICKS, ($urandom_range(0, 7) == 0) ?
			          ($urandom_range(0, 1) ? 32'd255 : 32'd0) : $urandom_range(1, 30));
			case ($urandom_range(0, 3))
				0:       write_reg(REG_OBSERVE_DURATION_MS, 32'd0);
				1:       write_reg(REG_OBSERVE_DURATION_MS, $urandom_range(0, 20000));
				2:       write_reg(REG_OBSERVE_DURATION_MS, 32'hFFFF_FFFF);
				default: write_reg(REG_OBSERVE_DURATION_MS, $urandom);
			endcase
			write_reg(REG_FALL_HINT_MASK, ($urandom_range(0, 7) == 0) ?
			          ($urandom_range(0, 1) ? 32'hFF : 32'h00) : $urandom_range(1, 255));

			// Some phases run back to back on both channels, most idle at random.
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			thr      = int'(filter_cfg.active_threshold);
			low_thr  = int'(filter_cfg.low_activity_threshold);
			mask     = filter_cfg.fall_hint_mask;
			obs      = filter_cfg.observe_duration_ms;
			run_left = 0;

			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (run_left == 0) begin
					pick = $urandom_range(0, 99);
					if (pick < 25)      mode = BURST_ACTIVE;
					else if (pick < 50) mode = BURST_HINT_ACTIVE;
					else if (pick < 72) mode = BURST_LOW;
					else if (pick < 82) mode = BURST_HINT_QUIET;
					else if (pick < 96) mode = BURST_NOISE;
					else                mode = BURST_OFFLINE;
					run_left = (mode == BURST_OFFLINE) ? 1 : $urandom_range(1, 8);
				end
				run_left--;

				p.motion = 8'($urandom_range(0, 255));
				if (mode == BURST_ACTIVE || (mode == BURST_HINT_ACTIVE && $urandom_range(0, 1)))
					p.motion = (thr == 255) ? 8'd255 : 8'($urandom_range(thr + 1, 255));
				else if (mode == BURST_HINT_QUIET)
					p.motion = 8'($urandom_range(0, thr));
				else if (mode == BURST_LOW)
					p.motion = 8'($urandom_range(0, low_thr));

				p.status_byte = 8'($urandom_range(0, 255));
				p.status_byte[OFFLINE_BIT] = (mode == BURST_OFFLINE);

				p.fall_hint_bits = 8'($urandom_range(0, 255));
				if (mode == BURST_HINT_ACTIVE || mode == BURST_HINT_QUIET) begin
					if (mask != 0)
						while ((p.fall_hint_bits & mask) == 0)
							p.fall_hint_bits = 8'($urandom_range(1, 255));
				end else if ($urandom_range(0, 9) < 7) begin
					p.fall_hint_bits = p.fall_hint_bits & ~mask;
				end

				p.static_ms = $urandom;
				if (mode == BURST_LOW && $urandom_range(0, 3) != 0)
					p.static_ms = $urandom_range(32'hFFFF_FFFF, obs);

				send_packet(p, PREDICT, REASON_NONE);
			end
		end

		// Drain: lower valid, wait for every result, then allow the pipeline depth
		// again in case anything unasked-for comes out.
		if (pkt_valid) begin
			@(negedge clk);
			pkt_valid = 1'b0;
		end
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display({"Sent %0d packets and %0d register writes over %0d phases; ",
		          "%0d results checked."},
		         packets_sent, reg_writes, RANDOM_PHASES + 4, results_checked);
		$display({"Reasons seen: none %0d, offline %0d, confirmed %0d, ",
		          "confirming %0d, no activity %0d, low activity %0d."},
		         reason_seen[REASON_NONE], reason_seen[REASON_OFFLINE],
		         reason_seen[REASON_CONFIRMED], reason_seen[REASON_CONFIRMING],
		         reason_seen[REASON_NO_ACTIVE], reason_seen[REASON_LOW_ACT]);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results never arrived", mismatches,
			         pending_results.size());
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/fhcf_pkg.sv
hdl/fhcf_cfg_regs.sv
hdl/fhcf_step.sv
hdl/fall_hint_confirmation_filter_core.sv
hdl/fhcf_checker.sv
tb/tb.sv
